FILE: rtl/lpff_pkg.sv
// shared types, constants and tables for the polar frame correction pipeline
// no dependencies; used by every module under rtl
`timescale 1ns / 1ps
package lpff_pkg;

  // cordic datapath widths
  localparam int XW = 36;
  localparam int ZW = 34;
  localparam int TAB_LEN = 24;

  // 1/K of the cordic gain, Q30
  localparam logic [29:0] INV_GAIN = 30'd652032874;

  localparam logic signed [ZW-1:0] HALF_TURN = 34'sh080000000;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sh040000000;

  // atan(2^-i) in binary-angle units, 2^32 per turn
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [1:0] {
    CFG_MIRROR = 2'd0,
    CFG_YAW    = 2'd1,
    CFG_FWD    = 2'd2
  } cfg_idx_t;

  // sideband that travels with each item
  typedef struct packed {
    logic        valid;
    logic        last;
    logic        pass;
    logic        fzero;
    logic        origin;
    logic [15:0] angle;
    logic [15:0] dist_mm;
    logic [15:0] aw;
  } side_t;

  typedef logic [31:0] tab45_t [45];

  // round((r * 2^(29-frac)) / 45), half up, for the remainder part of the angle scaling
  function automatic tab45_t make_tab45(int frac);
    tab45_t t;
    longint v;
    for (int r = 0; r < 45; r++) begin
      v = (longint'(r) << (29 - frac)) + 64'sd22;
      t[r] = 32'(v / 45);
    end
    return t;
  endfunction

endpackage

FILE: rtl/lpff_ang2bin.sv
// mirror, yaw, half-turn wrap, scale to binary angle, right-half fold
// depends on lpff_pkg
`timescale 1ns / 1ps
module lpff_ang2bin #(
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lpff_pkg::side_t                 sb_i,
  input  logic                            mirror_enable,
  input  logic signed [14:0]              yaw_offset,
  output lpff_pkg::side_t                 sb_o,
  output logic signed [lpff_pkg::XW-1:0]  x_o,
  output logic signed [lpff_pkg::ZW-1:0]  z_o
);

  localparam int F = ANGLE_FRAC_BITS;
  localparam int FULL_I = 360 << F;
  localparam int HALF_I = 180 << F;
  localparam int SW = (F + 9 > 18) ? F + 10 : 19;
  localparam int MW = F + 9;
  localparam int VW = SW - F - 3;
  localparam int PW = VW + 13;
  localparam int KW = PW - 16;
  localparam int S = F + 14;
  localparam int M45 = (1 << S) / 45;
  localparam int MMW = S - 4;
  localparam int QW = F + 4;
  localparam int ZW = lpff_pkg::ZW;
  localparam int XW = lpff_pkg::XW;

  localparam logic signed [SW-1:0] FULL_S = SW'(FULL_I);
  localparam logic signed [SW-1:0] HALF_S = SW'(HALF_I);
  localparam logic signed [12:0] RC45 = 13'sd1457;
  localparam logic [MMW-1:0] M45_U = MMW'(M45);
  localparam lpff_pkg::tab45_t TAB = lpff_pkg::make_tab45(F);

  lpff_pkg::side_t sb1, sb2, sb3, sb4, sb5, sb6, sb7, sb8;
  logic signed [SW-1:0] s1_sum, s2_sum, s3_r;
  logic signed [KW-1:0] s2_k;
  logic [45:0] s1_dprod;
  logic [31:0] dq2, dq3, dq4, dq5, dq6, dq7, dq8;
  logic [MW-1:0] s4_mag, s5_mag;
  logic s4_neg, s5_neg, s6_neg, s7_neg;
  logic [QW-1:0] s5_q, s6_q, s7_q;
  logic [6:0] s6_r;
  logic [5:0] s7_r;
  logic signed [ZW-1:0] s8_theta;

  logic signed [16:0] ang17;
  logic signed [SW-1:0] sum_next;
  logic signed [VW-1:0] v2;
  logic signed [PW-1:0] kprod;
  logic signed [SW-1:0] r_next;
  logic signed [SW-1:0] rc, a_full;
  lpff_pkg::side_t sb3_aw;
  logic [MW+MMW-1:0] qprod;
  logic [MW-1:0] r45w;
  logic [32:0] tmag;

  always_comb begin
    ang17 = mirror_enable ? -$signed({sb_i.angle[15], sb_i.angle})
                          : $signed({sb_i.angle[15], sb_i.angle});
    sum_next = SW'(ang17) + SW'(yaw_offset) + HALF_S;
    v2 = VW'(s1_sum >>> (F + 3));
    kprod = PW'(v2) * PW'(RC45);
    r_next = s2_sum - SW'(s2_k) * FULL_S;
    if (s3_r < 0) begin
      rc = s3_r + FULL_S;
    end else if (s3_r >= FULL_S) begin
      rc = s3_r - FULL_S;
    end else begin
      rc = s3_r;
    end
    a_full = rc - HALF_S;
    // wrapped angle joins the sideband of its own item
    sb3_aw = sb3;
    sb3_aw.aw = a_full[15:0];
    qprod = (MW + MMW)'(s4_mag) * (MW + MMW)'(M45_U);
    r45w = s5_mag - MW'(s5_q) * MW'(45);
    tmag = 33'({s7_q, {(29 - F){1'b0}}}) + 33'(TAB[s7_r]);
  end

  always_ff @(posedge clk) begin
    // stage 1: mirror and yaw, distance prescale
    s1_sum <= sum_next;
    s1_dprod <= 46'(sb_i.dist_mm) * 46'(lpff_pkg::INV_GAIN);
    // stage 2: turn count estimate
    s2_sum <= s1_sum;
    s2_k <= kprod[PW-1:16];
    dq2 <= 32'((s1_dprod + 46'd8192) >> 14);
    // stage 3: remainder
    s3_r <= r_next;
    dq3 <= dq2;
    // stage 4: fix-up and center
    s4_neg <= a_full[SW-1];
    s4_mag <= a_full[SW-1] ? MW'(-a_full) : MW'(a_full);
    dq4 <= dq3;
    // stage 5: split magnitude by 45
    s5_q <= qprod[S+QW-1:S];
    s5_mag <= s4_mag;
    s5_neg <= s4_neg;
    dq5 <= dq4;
    // stage 6
    s6_q <= s5_q;
    s6_r <= r45w[6:0];
    s6_neg <= s5_neg;
    dq6 <= dq5;
    // stage 7: one-step quotient correction
    if (s6_r >= 7'd45) begin
      s7_q <= s6_q + 1'b1;
      s7_r <= 6'(s6_r - 7'd45);
    end else begin
      s7_q <= s6_q;
      s7_r <= s6_r[5:0];
    end
    s7_neg <= s6_neg;
    dq7 <= dq6;
    // stage 8: binary angle
    s8_theta <= s7_neg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    dq8 <= dq7;
    // stage 9: fold into the right half plane
    if (s8_theta > lpff_pkg::QUARTER_TURN) begin
      x_o <= -$signed({4'b0, dq8});
      z_o <= s8_theta - lpff_pkg::HALF_TURN;
    end else if (s8_theta < -lpff_pkg::QUARTER_TURN) begin
      x_o <= -$signed({4'b0, dq8});
      z_o <= s8_theta + lpff_pkg::HALF_TURN;
    end else begin
      x_o <= $signed({4'b0, dq8});
      z_o <= s8_theta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb1.valid <= 1'b0;
      sb2.valid <= 1'b0;
      sb3.valid <= 1'b0;
      sb4.valid <= 1'b0;
      sb5.valid <= 1'b0;
      sb6.valid <= 1'b0;
      sb7.valid <= 1'b0;
      sb8.valid <= 1'b0;
      sb_o.valid <= 1'b0;
    end else begin
      sb1 <= sb_i;
      sb2 <= sb1;
      sb3 <= sb2;
      sb4 <= sb3_aw;
      sb5 <= sb4;
      sb6 <= sb5;
      sb7 <= sb6;
      sb8 <= sb7;
      sb_o <= sb8;
    end
  end

endmodule

FILE: rtl/lpff_rot.sv
// rotation-mode cordic, one registered iteration per stage
// depends on lpff_pkg
`timescale 1ns / 1ps
module lpff_rot #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lpff_pkg::side_t                 sb_i,
  input  logic signed [lpff_pkg::XW-1:0]  x_i,
  input  logic signed [lpff_pkg::ZW-1:0]  z_i,
  output lpff_pkg::side_t                 sb_o,
  output logic signed [lpff_pkg::XW-1:0]  x_o,
  output logic signed [lpff_pkg::XW-1:0]  y_o
);

  localparam int N = CORDIC_STAGES;
  localparam int XW = lpff_pkg::XW;
  localparam int ZW = lpff_pkg::ZW;

  lpff_pkg::side_t sb [N+1];
  logic signed [XW-1:0] xa [N+1];
  logic signed [XW-1:0] ya [N+1];
  logic signed [ZW-1:0] za [N+1];

  assign sb[0] = sb_i;
  assign xa[0] = x_i;
  assign ya[0] = '0;
  assign za[0] = z_i;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [ZW-1:0] AT =
      $signed({{(ZW - 32){1'b0}}, lpff_pkg::ATAN_TAB[i]});
    always_ff @(posedge clk) begin
      if (!za[i][ZW-1]) begin
        xa[i+1] <= xa[i] - (ya[i] >>> i);
        ya[i+1] <= ya[i] + (xa[i] >>> i);
        za[i+1] <= za[i] - AT;
      end else begin
        xa[i+1] <= xa[i] + (ya[i] >>> i);
        ya[i+1] <= ya[i] - (xa[i] >>> i);
        za[i+1] <= za[i] + AT;
      end
      if (rst) begin
        sb[i+1].valid <= 1'b0;
      end else begin
        sb[i+1] <= sb[i];
      end
    end
  end

  assign sb_o = sb[N];
  assign x_o = xa[N];
  assign y_o = ya[N];

endmodule

FILE: rtl/lpff_vec.sv
// vectoring-mode cordic, one registered iteration per stage
// depends on lpff_pkg
`timescale 1ns / 1ps
module lpff_vec #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lpff_pkg::side_t                 sb_i,
  input  logic signed [lpff_pkg::XW-1:0]  x_i,
  input  logic signed [lpff_pkg::XW-1:0]  y_i,
  input  logic signed [lpff_pkg::ZW-1:0]  z_i,
  output lpff_pkg::side_t                 sb_o,
  output logic signed [lpff_pkg::XW-1:0]  x_o,
  output logic signed [lpff_pkg::ZW-1:0]  z_o
);

  localparam int N = CORDIC_STAGES;
  localparam int XW = lpff_pkg::XW;
  localparam int ZW = lpff_pkg::ZW;

  lpff_pkg::side_t sb [N+1];
  logic signed [XW-1:0] xa [N+1];
  logic signed [XW-1:0] ya [N+1];
  logic signed [ZW-1:0] za [N+1];

  assign sb[0] = sb_i;
  assign xa[0] = x_i;
  assign ya[0] = y_i;
  assign za[0] = z_i;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [ZW-1:0] AT =
      $signed({{(ZW - 32){1'b0}}, lpff_pkg::ATAN_TAB[i]});
    always_ff @(posedge clk) begin
      if (ya[i][XW-1]) begin
        xa[i+1] <= xa[i] - (ya[i] >>> i);
        ya[i+1] <= ya[i] + (xa[i] >>> i);
        za[i+1] <= za[i] - AT;
      end else begin
        xa[i+1] <= xa[i] + (ya[i] >>> i);
        ya[i+1] <= ya[i] - (xa[i] >>> i);
        za[i+1] <= za[i] + AT;
      end
      if (rst) begin
        sb[i+1].valid <= 1'b0;
      end else begin
        sb[i+1] <= sb[i];
      end
    end
  end

  assign sb_o = sb[N];
  assign x_o = xa[N];
  assign z_o = za[N];

endmodule

FILE: rtl/lpff_bin2ang.sv
// binary angle back to degree units, magnitude gain removal and saturation
// depends on lpff_pkg
`timescale 1ns / 1ps
module lpff_bin2ang #(
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lpff_pkg::side_t                 sb_i,
  input  logic signed [lpff_pkg::XW-1:0]  x_i,
  input  logic signed [lpff_pkg::ZW-1:0]  z_i,
  output lpff_pkg::side_t                 sb_o,
  output logic [15:0]                     angle_o,
  output logic [16:0]                     dist_o
);

  localparam int F = ANGLE_FRAC_BITS;
  localparam int AMW = F + 9;
  localparam int ZPW = 32 + AMW;
  localparam logic [AMW-1:0] FULL_U = AMW'(360 << F);
  localparam logic [AMW-1:0] HALF_U = AMW'(180 << F);
  localparam logic signed [31:0] FULL_S = 32'(360 << F);

  lpff_pkg::side_t sb1, sb2, sb3;
  logic [31:0] s1_zabs;
  logic s1_neg, s2_neg, s3_neg;
  logic [34:0] s1_x;
  logic [ZPW-1:0] s2_zp;
  logic [46:0] s2_ph;
  logic [47:0] s2_pl;
  logic [AMW-1:0] s3_am;
  logic [19:0] s3_mag;

  logic [31:0] zw;
  logic [ZPW:0] zsum;
  logic [65:0] msum;
  logic signed [31:0] a32;

  always_comb begin
    zw = z_i[31:0];
    zsum = (ZPW + 1)'(s2_zp) + (ZPW + 1)'(33'h080000000);
    msum = 66'({s2_ph, 18'b0}) + 66'(s2_pl) + (66'd1 << 45);
    if (s3_neg) begin
      a32 = -$signed(32'(s3_am));
    end else if (s3_am >= HALF_U) begin
      a32 = $signed(32'(s3_am)) - FULL_S;
    end else begin
      a32 = $signed(32'(s3_am));
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: wrap to half turn, absolute value
    s1_neg <= zw[31];
    s1_zabs <= zw[31] ? (~zw + 32'd1) : zw;
    s1_x <= x_i[34:0];
    // stage 2: products
    s2_zp <= ZPW'(s1_zabs) * ZPW'(FULL_U);
    s2_ph <= 47'(s1_x[34:18]) * 47'(lpff_pkg::INV_GAIN);
    s2_pl <= 48'(s1_x[17:0]) * 48'(lpff_pkg::INV_GAIN);
    s2_neg <= s1_neg;
    // stage 3: rounding
    s3_am <= zsum[32 +: AMW];
    s3_mag <= msum[65:46];
    s3_neg <= s2_neg;
    // stage 4: sign, +180 to -180, saturation
    angle_o <= a32[15:0];
    dist_o <= (s3_mag > 20'h1FFFF) ? 17'h1FFFF : s3_mag[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb1.valid <= 1'b0;
      sb2.valid <= 1'b0;
      sb3.valid <= 1'b0;
      sb_o.valid <= 1'b0;
    end else begin
      sb1 <= sb_i;
      sb2 <= sb1;
      sb3 <= sb2;
      sb_o <= sb3;
    end
  end

endmodule

FILE: rtl/lidar_polar_frame_fix.sv
// top level of the polar frame correction pipeline: config registers,
// input and output registers, forward offset stage; uses lpff_pkg and all lpff_ modules
// throughput: one reading per clock, set by the fully pipelined cordic stages; busy stays low
// reset: synchronous rst clears the three registers and every valid bit, so results in flight are lost
// results leave on done for one cycle each; the receiver cannot stall
`timescale 1ns / 1ps
module lidar_polar_frame_fix #(
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [14:0] cfg_wdata,
  // reading in
  input  logic        start,
  output logic        busy,
  input  logic [15:0] angle_in,
  input  logic [15:0] dist_in,
  input  logic        last_in,
  // corrected reading out
  output logic        done,
  output logic [15:0] angle_out,
  output logic [16:0] dist_out,
  output logic        last_out
);

  localparam int XW = lpff_pkg::XW;
  localparam int ZW = lpff_pkg::ZW;

  // configuration registers
  logic mirror_enable;
  logic signed [14:0] yaw_offset;
  logic signed [10:0] forward_offset_mm;

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_enable <= 1'b0;
      yaw_offset <= '0;
      forward_offset_mm <= '0;
    end else if (cfg_we) begin
      case (lpff_pkg::cfg_idx_t'(cfg_addr))
        lpff_pkg::CFG_MIRROR: mirror_enable <= cfg_wdata[0];
        lpff_pkg::CFG_YAW:    yaw_offset <= cfg_wdata;
        lpff_pkg::CFG_FWD:    forward_offset_mm <= cfg_wdata[10:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // the pipeline never holds off a transfer
  assign busy = 1'b0;

  // input register: each reading is tagged with the bypass flags it needs at the end
  lpff_pkg::side_t in_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sb.valid <= 1'b0;
    end else begin
      in_sb.valid <= start;
      in_sb.last <= last_in;
      in_sb.pass <= !mirror_enable && (yaw_offset == '0) && (forward_offset_mm == '0);
      in_sb.fzero <= (forward_offset_mm == '0);
      in_sb.origin <= 1'b0;
      in_sb.angle <= angle_in;
      in_sb.dist_mm <= dist_in;
      in_sb.aw <= '0;
    end
  end

  // angle wrap and conversion to binary angle, 9 stages
  lpff_pkg::side_t a2b_sb;
  logic signed [XW-1:0] a2b_x;
  logic signed [ZW-1:0] a2b_z;

  lpff_ang2bin #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_ang2bin (
    .clk          (clk),
    .rst          (rst),
    .sb_i         (in_sb),
    .mirror_enable(mirror_enable),
    .yaw_offset   (yaw_offset),
    .sb_o         (a2b_sb),
    .x_o          (a2b_x),
    .z_o          (a2b_z)
  );

  // polar to cartesian
  lpff_pkg::side_t rot_sb;
  logic signed [XW-1:0] rot_x, rot_y;

  lpff_rot #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_rot (
    .clk (clk),
    .rst (rst),
    .sb_i(a2b_sb),
    .x_i (a2b_x),
    .z_i (a2b_z),
    .sb_o(rot_sb),
    .x_o (rot_x),
    .y_o (rot_y)
  );

  // forward offset stage: add offset to x, then detect origin and fold to x >= 0
  lpff_pkg::side_t fa_sb, fb_sb, fa_sb_org;
  logic signed [XW-1:0] fa_x, fa_y, fb_x, fb_y;
  logic signed [ZW-1:0] fb_z;
  logic signed [XW-1:0] fwd_q16;
  logic fa_origin;

  assign fwd_q16 = $signed({{(XW - 27){forward_offset_mm[10]}}, forward_offset_mm, 16'b0});
  assign fa_origin = (fa_x == '0) && (fa_y == '0);

  // origin flag joins the sideband of the same item
  always_comb begin
    fa_sb_org = fa_sb;
    fa_sb_org.origin = fa_origin;
  end

  always_ff @(posedge clk) begin
    fa_x <= rot_x + fwd_q16;
    fa_y <= rot_y;
    if (fa_x[XW-1]) begin
      fb_x <= -fa_x;
      fb_y <= -fa_y;
      fb_z <= lpff_pkg::HALF_TURN;
    end else begin
      fb_x <= fa_x;
      fb_y <= fa_y;
      fb_z <= '0;
    end
    if (rst) begin
      fa_sb.valid <= 1'b0;
      fb_sb.valid <= 1'b0;
    end else begin
      fa_sb <= rot_sb;
      fb_sb <= fa_sb_org;
    end
  end

  // cartesian back to polar
  lpff_pkg::side_t vec_sb;
  logic signed [XW-1:0] vec_x;
  logic signed [ZW-1:0] vec_z;

  lpff_vec #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_vec (
    .clk (clk),
    .rst (rst),
    .sb_i(fb_sb),
    .x_i (fb_x),
    .y_i (fb_y),
    .z_i (fb_z),
    .sb_o(vec_sb),
    .x_o (vec_x),
    .z_o (vec_z)
  );

  // degree units, gain removal, 4 stages
  lpff_pkg::side_t b2a_sb;
  logic [15:0] b2a_angle;
  logic [16:0] b2a_dist;

  lpff_bin2ang #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_bin2ang (
    .clk    (clk),
    .rst    (rst),
    .sb_i   (vec_sb),
    .x_i    (vec_x),
    .z_i    (vec_z),
    .sb_o   (b2a_sb),
    .angle_o(b2a_angle),
    .dist_o (b2a_dist)
  );

  // output register: pick bypass, offset-free, origin or full cordic result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b2a_sb.valid;
    end
    last_out <= b2a_sb.last;
    if (b2a_sb.pass) begin
      angle_out <= b2a_sb.angle;
      dist_out <= {1'b0, b2a_sb.dist_mm};
    end else if (b2a_sb.fzero) begin
      angle_out <= b2a_sb.aw;
      dist_out <= {1'b0, b2a_sb.dist_mm};
    end else if (b2a_sb.origin) begin
      angle_out <= '0;
      dist_out <= '0;
    end else begin
      angle_out <= b2a_angle;
      dist_out <= b2a_dist;
    end
  end

endmodule
